// File: rtl/core/cth_pkg.sv
// Shared types, constants and lookup tables for the canonical tetramer histogram.
package cth_pkg;

  localparam int COUNT_WIDTH   = 24;
  localparam int FRACTION_BITS = 24;
  localparam int FREQ_W        = FRACTION_BITS + 1;
  localparam int NUM_BINS      = 136;
  localparam int BIN_W         = $clog2(NUM_BINS);
  localparam int KMER_W        = 8;
  localparam int CHAR_W        = 8;
  localparam int REQ_W         = 2;
  localparam int RUN_W         = 3;
  localparam int KMER_LEN      = 4;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] base_char;
    logic [BIN_W-1:0]  bin_index;
  } cth_cmd_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] bin_count;
    logic [COUNT_WIDTH-1:0] total_count;
    logic [FREQ_W-1:0]      frequency;
    logic [KMER_W-1:0]      representative_kmer;
  } cth_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_UPD,
    ST_READ_LATCH,
    ST_DIVIDE,
    ST_REPLY
  } cth_state_t;

  // Base encoding: bit 2 flags a valid base, bits 1:0 the 2-bit code.
  function automatic logic [2:0] encode_nt(input logic [CHAR_W-1:0] ch);
    logic [2:0] enc;
    unique case (ch)
      "A", "a": enc = 3'b100;
      "C", "c": enc = 3'b101;
      "G", "g": enc = 3'b110;
      "T", "t": enc = 3'b111;
      default:  enc = 3'b000;
    endcase
    return enc;
  endfunction

  function automatic logic [KMER_W-1:0] rc_code(input logic [KMER_W-1:0] code);
    logic [KMER_W-1:0] r;
    logic [KMER_W-1:0] c;
    r = '0;
    c = code;
    for (int k = 0; k < KMER_LEN; k++) begin
      r = {r[KMER_W-3:0], ~c[1:0]};
      c = c >> 2;
    end
    return r;
  endfunction

  function automatic logic [255:0][BIN_W-1:0] make_code_to_bin();
    logic [255:0][BIN_W-1:0] tab;
    logic [255:0]            taken;
    logic [KMER_W-1:0]       r;
    int                      nxt;
    tab   = '0;
    taken = '0;
    nxt   = 0;
    for (int c = 0; c < 256; c++) begin
      if (!taken[c]) begin
        r        = rc_code(KMER_W'(c));
        tab[c]   = BIN_W'(nxt);
        tab[r]   = BIN_W'(nxt);
        taken[c] = 1'b1;
        taken[r] = 1'b1;
        nxt++;
      end
    end
    return tab;
  endfunction

  function automatic logic [NUM_BINS-1:0][KMER_W-1:0] make_bin_rep();
    logic [NUM_BINS-1:0][KMER_W-1:0] rep;
    logic [255:0]                    taken;
    logic [KMER_W-1:0]               r;
    int                              nxt;
    rep   = '0;
    taken = '0;
    nxt   = 0;
    for (int c = 0; c < 256; c++) begin
      if (!taken[c]) begin
        r        = rc_code(KMER_W'(c));
        rep[nxt] = KMER_W'(c);
        taken[c] = 1'b1;
        taken[r] = 1'b1;
        nxt++;
      end
    end
    return rep;
  endfunction

  localparam logic [255:0][BIN_W-1:0]       CODE_TO_BIN = make_code_to_bin();
  localparam logic [NUM_BINS-1:0][KMER_W-1:0] BIN_REP   = make_bin_rep();

endpackage

// File: rtl/core/canonical_tetramer_histogram_unit.sv
// Top level of the canonical tetramer histogram: sequencer, counters and result register.
//
// Commands are accepted on a cycle with start high and busy low. A push folds
// one ASCII base into the rolling 4-mer; an A/C/G/T in either case shifts in,
// anything else restarts the run. From the fourth base in a row on, each push
// bumps the canonical bin (4-mer and its reverse complement share one of 136
// bins) and the total, both saturating. A push that counts holds busy through
// the update state for the read-modify-write of the bin store; other pushes,
// clears and the unused request code leave busy low. A read keeps busy high in
// every state it passes after accept: the accept cycle issues the store read,
// the latch state latches the count, the restoring divider forms count / total
// (FRACTION_BITS + 1 quotient bits, then a completion flag), and the reply
// state presents the word. With a zero total the divider is skipped and the
// word follows the latch state directly.
// The result word is valid only while done is high, for exactly one cycle; the
// receiver cannot hold it off, so it must capture it then. A bin index past
// 135 returns zero count, frequency and representative but the true total.
// Clear and reset empty the histogram at once through per-bin valid flags, so
// there is no clearing sweep.
module canonical_tetramer_histogram_unit
  import cth_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cth_cmd_t    cmd,
  output logic        busy,
  output logic        done,
  output cth_result_t result
);

  cth_state_t state, state_next;

  // rolling k-mer state
  logic [KMER_W-1:0]      rolling_code;
  logic [RUN_W-1:0]       valid_run;
  logic [COUNT_WIDTH-1:0] kmer_total;
  logic [NUM_BINS-1:0]    bin_valid;

  // per-command working registers
  logic [BIN_W-1:0]       bin_sel;
  logic                   in_range;
  logic [COUNT_WIDTH-1:0] bin_pick;

  logic                   accept;
  logic [2:0]             enc;
  logic [KMER_W-1:0]      roll_next;
  logic [RUN_W-1:0]       run_next;
  logic                   push_counts;

  logic                   ram_we;
  logic [BIN_W-1:0]       ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] bin_now;

  logic                   div_go;
  logic                   div_done;
  logic [FREQ_W-1:0]      div_q;

  assign accept    = start && !busy;
  assign enc       = encode_nt(cmd.base_char);
  assign roll_next = {rolling_code[KMER_W-3:0], enc[1:0]};
  assign run_next  = (valid_run < RUN_W'(KMER_LEN)) ? valid_run + 1'b1 : valid_run;
  assign push_counts = enc[2] && (run_next == RUN_W'(KMER_LEN));

  // an entry not written since clear reads as zero
  assign bin_now   = bin_valid[bin_sel] ? ram_rdata : '0;
  assign ram_wdata = (bin_now == '1) ? bin_now : bin_now + 1'b1;

  // count of the bin being read; zero past the last bin
  assign bin_pick  = in_range ? bin_now : '0;

  // store read address: the addressed bin for a read, the new 4-mer's bin for a push
  always_comb begin
    if (cmd.req_type == REQ_READ) begin
      ram_raddr = cmd.bin_index;
    end else begin
      ram_raddr = CODE_TO_BIN[roll_next];
    end
  end

  cth_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(NUM_BINS)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(bin_sel),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // the divider loads the count straight from the store on the latch cycle
  cth_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .dividend(bin_pick),
    .divisor (kmer_total),
    .done    (div_done),
    .quotient(div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd.req_type == REQ_READ) begin
            state_next = ST_READ_LATCH;
          end else if (cmd.req_type == REQ_PUSH && push_counts) begin
            state_next = ST_PUSH_UPD;
          end
        end
      end
      ST_PUSH_UPD:   state_next = ST_IDLE;
      ST_READ_LATCH: state_next = (kmer_total == '0) ? ST_REPLY : ST_DIVIDE;
      ST_DIVIDE:     state_next = div_done ? ST_REPLY : ST_DIVIDE;
      ST_REPLY:      state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy   = 1'b1;
    done   = 1'b0;
    ram_we = 1'b0;
    div_go = 1'b0;
    unique case (state)
      ST_IDLE:       busy   = 1'b0;
      ST_PUSH_UPD:   ram_we = 1'b1;
      ST_READ_LATCH: div_go = (kmer_total != '0);
      ST_DIVIDE:     ;
      ST_REPLY:      done   = 1'b1;
      default:       ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // histogram control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rolling_code <= '0;
      valid_run    <= '0;
      kmer_total   <= '0;
      bin_valid    <= '0;
    end else if (accept && cmd.req_type == REQ_CLEAR) begin
      rolling_code <= '0;
      valid_run    <= '0;
      kmer_total   <= '0;
      bin_valid    <= '0;
    end else if (accept && cmd.req_type == REQ_PUSH) begin
      if (enc[2]) begin
        rolling_code <= roll_next;
        valid_run    <= run_next;
        if (push_counts && kmer_total != '1) begin
          kmer_total <= kmer_total + 1'b1;
        end
      end else begin
        rolling_code <= '0;
        valid_run    <= '0;
      end
    end else if (ram_we) begin
      bin_valid[bin_sel] <= 1'b1;
    end
  end

  // working registers and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      bin_sel  <= ram_raddr;
      in_range <= (cmd.bin_index < BIN_W'(NUM_BINS));
    end
    if (state == ST_READ_LATCH) begin
      result.bin_count         <= bin_pick;
      result.total_count       <= kmer_total;
      result.representative_kmer <= in_range ? BIN_REP[bin_sel] : '0;
      result.frequency         <= '0;
    end
    if (div_done) begin
      result.frequency <= div_q;
    end
  end

endmodule

// File: rtl/core/cth_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cth_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 136
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/cth_divider.sv
// Restoring divider: one quotient bit per cycle for count * 2^F / total.
module cth_divider
  import cth_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic [COUNT_WIDTH-1:0] dividend,
  input  logic [COUNT_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [FREQ_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(FRACTION_BITS + 1);

  logic                   running;
  logic [STEP_W-1:0]      step;
  logic [COUNT_WIDTH:0]   rem;
  logic [COUNT_WIDTH-1:0] div;
  logic                   ge;
  logic [COUNT_WIDTH:0]   rem_sub;

  // dividend <= divisor, so the partial remainder never exceeds COUNT_WIDTH+1 bits
  assign ge      = rem >= {1'b0, div};
  assign rem_sub = ge ? rem - {1'b0, div} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
      end else if (running && step == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem      <= {1'b0, dividend};
      div      <= divisor;
      quotient <= '0;
      step     <= STEP_W'(FRACTION_BITS);
    end else if (running) begin
      rem      <= {rem_sub[COUNT_WIDTH-1:0], 1'b0};
      quotient <= {quotient[FREQ_W-2:0], ge};
      step     <= step - 1'b1;
    end
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the canonical tetramer histogram unit.
`timescale 1ns / 100ps

module tb_top
  import cth_pkg::*;
;

  // Request code that the block must ignore; the package names only the used ones.
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  localparam int RANDOM_WORDS = 600;
  localparam int MIN_READS    = 48;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;
  localparam int IDLE_PCT     = 13;
  // Quiet stretch of the sender: no random gaps while this many words go out.
  localparam int QUIET_FIRST  = 200;
  localparam int QUIET_LAST   = 350;
  // The sender holds here until every awaited reply has come back.
  localparam int DRAIN_AT_A   = 26;
  localparam int DRAIN_AT_B   = 420;

  logic        clk;
  logic        rst;
  logic        start = 1'b0;
  cth_cmd_t    cmd   = '0;
  logic        busy;
  logic        done;
  cth_result_t result;

  canonical_tetramer_histogram_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // ---------------------------------------------------------------------------
  // Clock and the single reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the rolling 4-mer and the histogram
  // ---------------------------------------------------------------------------
  logic [KMER_W-1:0]      kmer_of_bin [NUM_BINS];   // lowest code of each bin
  logic [7:0]             bin_of_kmer [256];        // canonical bin of each code
  logic [KMER_W-1:0]      roll_kmer;
  int unsigned            run_len;                  // valid bases in a row, stops at 4
  logic [COUNT_WIDTH-1:0] bin_tally [NUM_BINS];
  logic [COUNT_WIDTH-1:0] kmer_sum;

  cth_cmd_t    pending_words[$];    // words still to be sent
  cth_result_t awaited_replies[$];  // predicted read replies, oldest first

  string nt_letters = "ACGTacgt";

  int unsigned sent_words;
  int unsigned n_push, n_counted, n_read, n_clear, n_spare, n_checked;
  int unsigned n_reads_queued;
  int unsigned fail_count;
  bit          took = 1'b0;   // word on cmd was taken at the last rising edge

  // Numbers bins in order of first appearance over codes 0..255, pairing each
  // code with its reverse complement.
  function automatic void build_bin_map();
    bit          claimed [256];
    int unsigned twin;
    int unsigned next_bin;
    next_bin = 0;
    foreach (claimed[i]) claimed[i] = 1'b0;
    for (int c = 0; c < 256; c++) begin
      if (!claimed[c]) begin
        twin = 0;
        for (int k = 0; k < 4; k++)
          twin = (twin << 2) | (3 - ((c >> (2 * k)) & 3));
        twin &= 8'hFF;
        bin_of_kmer[c]       = 8'(next_bin);
        bin_of_kmer[twin]    = 8'(next_bin);
        claimed[c]           = 1'b1;
        claimed[twin]        = 1'b1;
        kmer_of_bin[next_bin] = KMER_W'(c);
        next_bin++;
      end
    end
  endfunction

  function automatic int base_code(input logic [CHAR_W-1:0] ch);
    case (ch)
      "A", "a": return 0;
      "C", "c": return 1;
      "G", "g": return 2;
      "T", "t": return 3;
      default:  return -1;
    endcase
  endfunction

  function automatic void wipe_histogram();
    roll_kmer = '0;
    run_len   = 0;
    kmer_sum  = '0;
    foreach (bin_tally[i]) bin_tally[i] = '0;
  endfunction

  // Applies one accepted word to the predicted state; a read queues its reply.
  function automatic void tally_command(input cth_cmd_t w);
    int          b;
    int unsigned slot;
    cth_result_t reply;
    longint unsigned scaled;
    case (w.req_type)
      REQ_PUSH: begin
        n_push++;
        b = base_code(w.base_char);
        if (b < 0) begin
          roll_kmer = '0;
          run_len   = 0;
        end else begin
          roll_kmer = {roll_kmer[KMER_W-3:0], 2'(b)};
          if (run_len < KMER_LEN) run_len++;
          if (run_len >= KMER_LEN) begin
            n_counted++;
            slot = bin_of_kmer[roll_kmer];
            if (bin_tally[slot] != '1) bin_tally[slot]++;
            if (kmer_sum != '1) kmer_sum++;
          end
        end
      end
      REQ_READ: begin
        n_read++;
        reply = '0;
        reply.total_count = kmer_sum;
        if (w.bin_index < NUM_BINS) begin
          reply.bin_count           = bin_tally[w.bin_index];
          reply.representative_kmer = kmer_of_bin[w.bin_index];
          if (kmer_sum != '0) begin
            scaled = longint'(bin_tally[w.bin_index]) << FRACTION_BITS;
            reply.frequency = FREQ_W'(scaled / longint'(kmer_sum));
          end
        end
        awaited_replies.push_back(reply);
      end
      REQ_CLEAR: begin
        n_clear++;
        wipe_histogram();
      end
      default: n_spare++;   // unused code: nothing moves
    endcase
  endfunction

  function automatic void note_failure(input string what, input cth_result_t want,
                                       input cth_result_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t mismatch (%s): want cnt=%0d tot=%0d freq=%h rep=%h, got cnt=%0d tot=%0d freq=%h rep=%h",
               $realtime, what, want.bin_count, want.total_count, want.frequency,
               want.representative_kmer, got.bin_count, got.total_count, got.frequency,
               got.representative_kmer);
  endfunction

  function automatic void check_reply(input cth_result_t got);
    cth_result_t want;
    if (awaited_replies.size() == 0) begin
      note_failure("reply with none awaited", '0, got);
      return;
    end
    want = awaited_replies.pop_front();
    n_checked++;
    if (got.bin_count !== want.bin_count || got.total_count !== want.total_count ||
        got.frequency !== want.frequency ||
        got.representative_kmer !== want.representative_kmer)
      note_failure("field", want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: replies are checked and accepted words predicted at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      took = 1'b0;
    end else begin
      if (done) check_reply(result);
      took = start && !busy;
      if (took) tally_command(cmd);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: changes inputs at the falling edge only
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    bit quiet;
    bit drain_hold;
    quiet      = (sent_words >= QUIET_FIRST) && (sent_words < QUIET_LAST);
    drain_hold = (sent_words == DRAIN_AT_A || sent_words == DRAIN_AT_B) &&
                 (awaited_replies.size() != 0);
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // word still waiting for busy to fall: hold it
    end else if (pending_words.size() == 0 || drain_hold ||
                 (!quiet && $urandom_range(0, 99) < IDLE_PCT)) begin
      start <= 1'b0;
    end else begin
      cmd   <= pending_words.pop_front();
      start <= 1'b1;
      sent_words++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void add_word(input logic [REQ_W-1:0] req, input int ch, input int idx);
    cth_cmd_t w;
    w.req_type  = req;
    w.base_char = CHAR_W'(ch);
    w.bin_index = BIN_W'(idx);
    if (req == REQ_READ) n_reads_queued++;
    pending_words.push_back(w);
  endfunction

  function automatic int any_byte();
    return $urandom_range(0, 255);
  endfunction

  function automatic int some_base();
    return nt_letters[$urandom_range(0, 7)];
  endfunction

  initial begin : stimulus
    int unsigned pick;
    int unsigned run;
    build_bin_map();
    wipe_histogram();

    // Directed: empty read, palindromic 4-mer, case mix, breaks, bin edges,
    // out-of-range index, unused code, clear.
    add_word(REQ_READ,  any_byte(), 0);          // total zero gives frequency zero
    add_word(REQ_PUSH,  "A", any_byte());
    add_word(REQ_PUSH,  "C", any_byte());
    add_word(REQ_PUSH,  "G", any_byte());
    add_word(REQ_PUSH,  "T", any_byte());        // ACGT is its own complement
    add_word(REQ_PUSH,  "a", any_byte());
    add_word(REQ_READ,  any_byte(), 27);
    add_word(REQ_PUSH,  "N", 8'hFF);             // ambiguous base breaks the run
    add_word(REQ_PUSH,  8'hC1, 8'h00);           // 'A' with the top bit set is no base
    add_word(REQ_PUSH,  "t", 8'h80);
    add_word(REQ_PUSH,  "t", 8'h7F);
    add_word(REQ_PUSH,  "T", any_byte());
    add_word(REQ_PUSH,  "t", any_byte());        // TTTT folds onto AAAA
    add_word(REQ_PUSH,  8'hFF, any_byte());
    add_word(REQ_PUSH,  8'h00, any_byte());
    add_word(REQ_READ,  8'h00, 0);
    add_word(REQ_READ,  8'hFF, NUM_BINS - 1);
    add_word(REQ_READ,  any_byte(), NUM_BINS);   // past the last bin
    add_word(REQ_READ,  any_byte(), 255);
    add_word(REQ_SPARE, "A", 0);                 // ignored outright
    add_word(REQ_READ,  any_byte(), 0);
    add_word(REQ_CLEAR, "G", 8'hAA);
    add_word(REQ_READ,  any_byte(), 0);
    add_word(REQ_PUSH,  "g", 8'h55);

    // Random: mostly runs of valid bases in random case, with reads between,
    // and some noise, clears and unused codes.
    while (pending_words.size() < RANDOM_WORDS || n_reads_queued < MIN_READS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        run = $urandom_range(1, 12);
        repeat (run) add_word(REQ_PUSH, some_base(), any_byte());
      end else if (pick < 85) begin
        add_word(REQ_READ, any_byte(), $urandom_range(0, NUM_BINS - 1));
      end else if (pick < 89) begin
        add_word(REQ_READ, any_byte(), $urandom_range(NUM_BINS, 255));
      end else if (pick < 94) begin
        add_word(REQ_PUSH, any_byte(), any_byte());
      end else if (pick < 97) begin
        add_word(REQ_CLEAR, any_byte(), any_byte());
      end else begin
        add_word(REQ_SPARE, any_byte(), any_byte());
      end
    end

    // Let everything go out and come back, then allow the read latency.
    @(posedge clk);
    while (pending_words.size() != 0 || start) @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (awaited_replies.size() != 0) begin
      fail_count++;
      $display("%0d replies never arrived", awaited_replies.size());
    end
    $display("covered %0d pushes (%0d counted 4-mers), %0d reads, %0d clears, %0d unused codes",
             n_push, n_counted, n_read, n_clear, n_spare);
    $display("%0d replies checked, %0d mismatches", n_checked, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("timeout waiting for the block");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/cth_pkg.sv
rtl/core/cth_ram.sv
rtl/core/cth_divider.sv
rtl/core/canonical_tetramer_histogram_unit.sv
tb/tb_top.sv
